/* rtl/vlt_pkg.sv */
`timescale 1ns / 1ps

package vlt_pkg;

	// default coordinate width of every voxel field
	localparam int COORD_BITS_DEF = 10;

	// operation codes of an input beat
	localparam logic OP_LOAD = 1'b0;
	localparam logic OP_STEP = 1'b1;

	// one-hot axis select
	localparam logic [2:0] PICK_X = 3'b001;
	localparam logic [2:0] PICK_Y = 3'b010;
	localparam logic [2:0] PICK_Z = 3'b100;

	// decision of one step, passed from the stepper to the top level
	typedef struct packed {
		logic [2:0] pick;  // axis advanced, one-hot
		logic       last;  // voxel entered equals the end voxel
	} vlt_step_t;

endpackage

/* rtl/vlt_in_if.sv */
`timescale 1ns / 1ps

interface vlt_in_if #(
	parameter int COORD_BITS = vlt_pkg::COORD_BITS_DEF
);
	logic                         valid;
	logic                         ready;
	logic                         operation;
	logic signed [COORD_BITS-1:0] start_x;
	logic signed [COORD_BITS-1:0] start_y;
	logic signed [COORD_BITS-1:0] start_z;
	logic signed [COORD_BITS-1:0] end_x;
	logic signed [COORD_BITS-1:0] end_y;
	logic signed [COORD_BITS-1:0] end_z;

	modport source (
		output valid, operation, start_x, start_y, start_z, end_x, end_y, end_z,
		input  ready
	);
	modport sink (
		input  valid, operation, start_x, start_y, start_z, end_x, end_y, end_z,
		output ready
	);
endinterface

/* rtl/vlt_out_if.sv */
`timescale 1ns / 1ps

interface vlt_out_if #(
	parameter int COORD_BITS = vlt_pkg::COORD_BITS_DEF
);
	logic                         valid;
	logic                         ready;
	logic signed [COORD_BITS-1:0] voxel_x;
	logic signed [COORD_BITS-1:0] voxel_y;
	logic signed [COORD_BITS-1:0] voxel_z;
	logic                         voxel_valid;
	logic                         last_voxel;

	modport source (
		output valid, voxel_x, voxel_y, voxel_z, voxel_valid, last_voxel,
		input  ready
	);
	modport sink (
		input  valid, voxel_x, voxel_y, voxel_z, voxel_valid, last_voxel,
		output ready
	);
endinterface

/* rtl/vlt_setup.sv */
`timescale 1ns / 1ps

// Segment setup: direction, span and initial crossing key per axis.
module vlt_setup #(
	parameter int COORD_BITS = vlt_pkg::COORD_BITS_DEF
) (
	input  logic signed [COORD_BITS-1:0] start_pos [3],
	input  logic signed [COORD_BITS-1:0] end_pos   [3],
	output logic                         dir_neg   [3],
	output logic [3*COORD_BITS:0]        key_init  [3],
	output logic [3*COORD_BITS:0]        key_inc   [3],
	output logic                         moving
);
	localparam int DW = COORD_BITS + 1;
	localparam int PW = 2 * COORD_BITS;
	localparam int KW = 3 * COORD_BITS + 1;

	logic signed [DW-1:0]   delta [3];
	logic [DW-1:0]          mag   [3];
	logic [COORD_BITS-1:0]  eff   [3];
	logic [PW-1:0]          prod  [3];

	// per-axis difference, magnitude; a zero span counts as one
	always_comb begin
		for (int a = 0; a < 3; a++) begin
			delta[a]   = DW'(end_pos[a]) - DW'(start_pos[a]);
			dir_neg[a] = delta[a][DW-1];
			mag[a]     = delta[a][DW-1] ? (~delta[a] + DW'(1)) : delta[a];
			eff[a]     = (mag[a] == '0) ? COORD_BITS'(1) : mag[a][COORD_BITS-1:0];
		end
		moving = (delta[0] != '0) || (delta[1] != '0) || (delta[2] != '0);
	end

	// key = product of the two other spans, increment twice that
	always_comb begin
		for (int a = 0; a < 3; a++) begin
			prod[a]     = PW'(eff[(a + 1) % 3]) * PW'(eff[(a + 2) % 3]);
			key_init[a] = KW'(prod[a]);
			key_inc[a]  = KW'({prod[a], 1'b0});
		end
	end

endmodule

/* rtl/vlt_stepper.sv */
`timescale 1ns / 1ps

// One traversal step: pick the axis with the earliest crossing, advance it.
module vlt_stepper #(
	parameter int COORD_BITS = vlt_pkg::COORD_BITS_DEF
) (
	input  logic signed [COORD_BITS-1:0] cur_pos  [3],
	input  logic signed [COORD_BITS-1:0] tgt_pos  [3],
	input  logic                         dir_neg  [3],
	input  logic [3*COORD_BITS:0]        key      [3],
	input  logic [3*COORD_BITS:0]        key_inc  [3],
	output logic signed [COORD_BITS-1:0] nxt_pos  [3],
	output logic [3*COORD_BITS:0]        nxt_key  [3],
	output vlt_pkg::vlt_step_t           step
);
	import vlt_pkg::*;

	logic done [3];
	logic lt_xy, lt_xz, lt_yz;

	// an axis at its end coordinate never wins while another axis is not at its end
	always_comb begin
		for (int a = 0; a < 3; a++) begin
			done[a] = (cur_pos[a] == tgt_pos[a]);
		end
		lt_xy = !done[0] && (done[1] || (key[0] < key[1]));
		lt_xz = !done[0] && (done[2] || (key[0] < key[2]));
		lt_yz = !done[1] && (done[2] || (key[1] < key[2]));
	end

	// ties between x and y go to y, any tie with z goes to z
	always_comb begin
		if (lt_xy) begin
			step.pick = lt_xz ? PICK_X : PICK_Z;
		end else begin
			step.pick = lt_yz ? PICK_Y : PICK_Z;
		end
	end

	// advance the picked axis and check for the end voxel
	always_comb begin
		for (int a = 0; a < 3; a++) begin
			if (step.pick[a]) begin
				nxt_pos[a] = dir_neg[a] ? (cur_pos[a] - COORD_BITS'(1))
				                        : (cur_pos[a] + COORD_BITS'(1));
				nxt_key[a] = key[a] + key_inc[a];
			end else begin
				nxt_pos[a] = cur_pos[a];
				nxt_key[a] = key[a];
			end
		end
		step.last = (nxt_pos[0] == tgt_pos[0]) && (nxt_pos[1] == tgt_pos[1]) &&
		            (nxt_pos[2] == tgt_pos[2]);
	end

endmodule

/* rtl/voxel_line_traversal_3d.sv */
`timescale 1ns / 1ps

// 3D voxel line traversal.
// req carries one beat per item: operation 0 loads a segment (start and end
// voxel), operation 1 asks for the next voxel of the loaded segment.
// rsp returns exactly one beat per req beat, in order. A step beat returns
// the voxel entered with voxel_valid set and last_voxel set on the end
// voxel; a load beat, or a step after the segment is finished, returns
// voxel_valid 0 with all other fields zero.
// A segment yields |dx| + |dy| + |dz| voxels.
// The response is registered and appears in the cycle after the req
// beat. Throughput: one item per clock; the crossing-key compare and key add
// of a step sit between the state registers and the response register, the
// span multipliers of a load between the req beat and the state registers.
// Reset clears the busy flag, the segment state and the response register;
// no segment is loaded afterwards. When rsp is stalled the response register
// holds and req.ready drops until the pending beat is taken; with rsp.ready
// high, req is accepted every cycle.
module voxel_line_traversal_3d #(
	parameter int COORD_BITS = vlt_pkg::COORD_BITS_DEF
) (
	input logic        clk,
	input logic        arst_n,
	vlt_in_if.sink     req,
	vlt_out_if.source  rsp
);
	import vlt_pkg::*;

	localparam int KW = 3 * COORD_BITS + 1;

	// traversal state
	logic signed [COORD_BITS-1:0] cur_q     [3];
	logic signed [COORD_BITS-1:0] tgt_q     [3];
	logic                         neg_q     [3];
	logic [KW-1:0]                key_q     [3];
	logic [KW-1:0]                inc_q     [3];
	logic                         busy_q;

	// response register
	logic                         out_v_q;
	logic signed [COORD_BITS-1:0] vox_q     [3];
	logic                         vox_valid_q;
	logic                         last_q;

	logic signed [COORD_BITS-1:0] start_pos [3];
	logic signed [COORD_BITS-1:0] end_pos   [3];
	logic                         ld_neg    [3];
	logic [KW-1:0]                ld_key    [3];
	logic [KW-1:0]                ld_inc    [3];
	logic                         ld_moving;
	logic signed [COORD_BITS-1:0] nxt_pos   [3];
	logic [KW-1:0]                nxt_key   [3];
	vlt_step_t                    st;
	logic                         accept;

	assign start_pos[0] = req.start_x;
	assign start_pos[1] = req.start_y;
	assign start_pos[2] = req.start_z;
	assign end_pos[0]   = req.end_x;
	assign end_pos[1]   = req.end_y;
	assign end_pos[2]   = req.end_z;

	vlt_setup #(.COORD_BITS(COORD_BITS)) u_setup (
		.start_pos (start_pos),
		.end_pos   (end_pos),
		.dir_neg   (ld_neg),
		.key_init  (ld_key),
		.key_inc   (ld_inc),
		.moving    (ld_moving)
	);

	vlt_stepper #(.COORD_BITS(COORD_BITS)) u_stepper (
		.cur_pos (cur_q),
		.tgt_pos (tgt_q),
		.dir_neg (neg_q),
		.key     (key_q),
		.key_inc (inc_q),
		.nxt_pos (nxt_pos),
		.nxt_key (nxt_key),
		.step    (st)
	);

	// accept while the response register is empty or being drained
	assign req.ready = !out_v_q || rsp.ready;
	assign accept    = req.valid && req.ready;

	// control: busy flag and response valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q  <= 1'b0;
			out_v_q <= 1'b0;
		end else begin
			if (accept) begin
				out_v_q <= 1'b1;
				if (req.operation == OP_LOAD) begin
					busy_q <= ld_moving;
				end else if (busy_q && st.last) begin
					busy_q <= 1'b0;
				end
			end else if (rsp.ready) begin
				out_v_q <= 1'b0;
			end
		end
	end

	// segment state and response payload
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vox_valid_q <= 1'b0;
			last_q      <= 1'b0;
			for (int a = 0; a < 3; a++) begin
				vox_q[a] <= '0;
				cur_q[a] <= '0;
				tgt_q[a] <= '0;
				neg_q[a] <= 1'b0;
				key_q[a] <= '0;
				inc_q[a] <= '0;
			end
		end else if (accept) begin
			vox_valid_q <= 1'b0;
			last_q      <= 1'b0;
			for (int a = 0; a < 3; a++) begin
				vox_q[a] <= '0;
			end
			if (req.operation == OP_LOAD) begin
				for (int a = 0; a < 3; a++) begin
					cur_q[a] <= start_pos[a];
					tgt_q[a] <= end_pos[a];
					neg_q[a] <= ld_neg[a];
					key_q[a] <= ld_key[a];
					inc_q[a] <= ld_inc[a];
				end
			end else if (busy_q) begin
				vox_valid_q <= 1'b1;
				last_q      <= st.last;
				for (int a = 0; a < 3; a++) begin
					cur_q[a] <= nxt_pos[a];
					key_q[a] <= nxt_key[a];
					vox_q[a] <= nxt_pos[a];
				end
			end
		end
	end

	assign rsp.valid       = out_v_q;
	assign rsp.voxel_x     = vox_q[0];
	assign rsp.voxel_y     = vox_q[1];
	assign rsp.voxel_z     = vox_q[2];
	assign rsp.voxel_valid = vox_valid_q;
	assign rsp.last_voxel  = last_q;

	// a busy walk always picks exactly one axis
	a_pick_onehot: assert property (@(posedge clk) disable iff (!arst_n)
		busy_q |-> $onehot(st.pick))
		else $error("step picked no axis or several axes");

	// the end voxel finishes the walk
	a_last_clears_busy: assert property (@(posedge clk) disable iff (!arst_n)
		(accept && req.operation == OP_STEP && busy_q && st.last) |=> !busy_q)
		else $error("walk still busy after end voxel");

	// a point segment never starts a walk
	a_point_idle: assert property (@(posedge clk) disable iff (!arst_n)
		(accept && req.operation == OP_LOAD && req.start_x == req.end_x &&
		 req.start_y == req.end_y && req.start_z == req.end_z) |=> !busy_q)
		else $error("point segment left block busy");

	// a step while idle emits nothing
	a_idle_step_empty: assert property (@(posedge clk) disable iff (!arst_n)
		(accept && req.operation == OP_STEP && !busy_q) |=>
		(!rsp.voxel_valid && !rsp.last_voxel))
		else $error("idle step emitted a voxel");

	// last flag only on an emitted voxel
	a_last_has_voxel: assert property (@(posedge clk) disable iff (!arst_n)
		(rsp.valid && rsp.last_voxel) |-> rsp.voxel_valid)
		else $error("last flag without a voxel");

endmodule
